// ===== src/playfair_digraph_cipher_unit_macros.svh =====
// Assertion macros shared by the cipher unit's RTL files.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_UNIT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define PDC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define PDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/pdc_pkg.sv =====
// Types, constants and square lookup functions of the cipher unit.
// Depends on nothing; imported by every module of the unit.
package pdc_pkg;

  localparam int LW      = 5;
  localparam int SIDE    = 5;
  localparam int ROW_W   = LW * SIDE;
  localparam int POS_W   = 3;
  localparam int IDX_W   = 3;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [LW-1:0] LETTER_X = LW'(23);
  localparam logic [LW-1:0] LETTER_J = LW'(9);
  localparam logic [LW-1:0] LETTER_I = LW'(8);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SIDE - 1);

  localparam logic [IDX_W-1:0] REG_KEY_ROW_0    = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_KEY_ROW_4    = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_DECRYPT_MODE = IDX_W'(5);

  typedef logic [SIDE-1:0][ROW_W-1:0] key_sq_t;

  localparam key_sq_t KEY_RESET = {
    ROW_W'(27025108), ROW_W'(18365868), ROW_W'(10755269),
    ROW_W'(4294706), ROW_W'(634325)
  };

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } loc_t;

  typedef struct packed {
    logic          err;
    logic          p0_v;
    logic [LW-1:0] p0_a;
    logic [LW-1:0] p0_b;
    logic          p1_v;
    logic [LW-1:0] p1_a;
  } pdc_job_t;

  function automatic logic [LW-1:0] key_cell(key_sq_t key, logic [POS_W-1:0] row,
                                             logic [POS_W-1:0] col);
    logic [ROW_W-1:0] kr;
    kr = key[row];
    return kr[int'(col) * LW +: LW];
  endfunction

  function automatic loc_t locate(key_sq_t key, logic [LW-1:0] code);
    loc_t res;
    res = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (key[r][c * LW +: LW] == code) begin
          res.found = 1'b1;
          res.row   = POS_W'(r);
          res.col   = POS_W'(c);
        end
      end
    end
    return res;
  endfunction

  function automatic logic [POS_W-1:0] shift_pos(logic [POS_W-1:0] p, logic dec);
    logic [POS_W-1:0] res;
    if (dec) begin
      res = (p == '0) ? POS_LAST : p - POS_W'(1);
    end else begin
      res = (p == POS_LAST) ? '0 : p + POS_W'(1);
    end
    return res;
  endfunction

endpackage

// ===== src/pdc_front.sv =====
// Front end: takes input transfers, applies the pairing rules, holds the
// open letter and queues a job when an item yields output. Uses pdc_pkg.
module pdc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pdc_pkg::key_sq_t       key,
  input  logic                   decrypt_mode,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [pdc_pkg::LW-1:0] in_letter_in,
  input  logic                   in_msg_end,
  input  logic                   q_full,
  output logic                   push,
  output pdc_pkg::pdc_job_t      job
);
  import pdc_pkg::*;

  logic [LW-1:0] held_letter_r, held_letter_nxt;
  logic          held_valid_r, held_valid_nxt;
  logic [LW-1:0] letter;
  logic          enc;
  logic          accept;
  loc_t          loc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign enc      = !decrypt_mode;
  assign letter   = (enc && in_letter_in == LETTER_J) ? LETTER_I : in_letter_in;
  assign loc      = locate(key, letter);

  always_comb begin
    job             = '0;
    held_letter_nxt = held_letter_r;
    held_valid_nxt  = held_valid_r;
    if (!loc.found) begin
      job.err = 1'b1;
    end else if (held_valid_r) begin
      job.p0_v = 1'b1;
      job.p0_a = held_letter_r;
      if (enc && held_letter_r == letter) begin
        job.p0_b = LETTER_X;
      end else begin
        job.p0_b       = letter;
        held_valid_nxt = 1'b0;
      end
    end else begin
      held_letter_nxt = letter;
      held_valid_nxt  = 1'b1;
    end
    if (in_msg_end && held_valid_nxt) begin
      job.p1_v       = enc;
      job.p1_a       = held_letter_nxt;
      held_valid_nxt = 1'b0;
    end
  end

  assign push = accept && (job.err || job.p0_v || job.p1_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_letter_r <= '0;
    end else if (accept) begin
      held_valid_r  <= held_valid_nxt;
      held_letter_r <= held_letter_nxt;
    end
  end

endmodule

// ===== src/pdc_queue.sv =====
// Short job queue between front and back end, built from registers.
// Uses pdc_pkg for the job type and depth.
`include "playfair_digraph_cipher_unit_macros.svh"
module pdc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pdc_pkg::pdc_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output pdc_pkg::pdc_job_t head_job
);
  import pdc_pkg::*;

  pdc_job_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `PDC_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full, "queue push while full")
  `PDC_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, head_valid, "queue pop while empty")

endmodule

// ===== src/pdc_back.sv =====
// Back end: unless stalled, sends one result per cycle from queued jobs into
// the output register, transforming each pair in the key square. Uses pdc_pkg.
`include "playfair_digraph_cipher_unit_macros.svh"
module pdc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pdc_pkg::key_sq_t       key,
  input  logic                   decrypt_mode,
  input  logic                   head_valid,
  input  pdc_pkg::pdc_job_t      head_job,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [pdc_pkg::LW-1:0] out_letter_out,
  output logic                   out_run_last,
  output logic                   out_bad_letter
);
  import pdc_pkg::*;

  logic          busy_r, busy_nxt;
  logic          err_r, err_nxt;
  logic          p0_r, p0_nxt;
  logic          p1_r, p1_nxt;
  logic          half_r, half_nxt;
  logic [LW-1:0] a0_r, b0_r, a1_r;
  logic          out_valid_r, out_valid_nxt;
  logic [LW-1:0] out_letter_r;
  logic          out_last_r, out_bad_r;

  logic          slot_free, step, final_step;
  logic [LW-1:0] pa, pb, res0, res1, res_letter;
  loc_t          la, lb;

  assign slot_free = !out_valid_r || !out_stall;
  assign step      = busy_r && slot_free;

  assign pa = p0_r ? a0_r : a1_r;
  assign pb = p0_r ? b0_r : LETTER_X;
  assign la = locate(key, pa);
  assign lb = locate(key, pb);

  always_comb begin
    if (la.row == lb.row) begin
      res0 = key_cell(key, la.row, shift_pos(la.col, decrypt_mode));
      res1 = key_cell(key, lb.row, shift_pos(lb.col, decrypt_mode));
    end else if (la.col == lb.col) begin
      res0 = key_cell(key, shift_pos(la.row, decrypt_mode), la.col);
      res1 = key_cell(key, shift_pos(lb.row, decrypt_mode), lb.col);
    end else begin
      res0 = key_cell(key, la.row, lb.col);
      res1 = key_cell(key, lb.row, la.col);
    end
  end

  assign res_letter = err_r ? '0 : (half_r ? res1 : res0);

  always_comb begin
    if (err_r) begin
      final_step = !p0_r && !p1_r;
    end else if (p0_r) begin
      final_step = half_r && !p1_r;
    end else begin
      final_step = half_r;
    end
  end

  assign pop = head_valid && (!busy_r || (step && final_step));

  always_comb begin
    busy_nxt = busy_r;
    err_nxt  = err_r;
    p0_nxt   = p0_r;
    p1_nxt   = p1_r;
    half_nxt = half_r;
    if (step) begin
      if (err_r) begin
        err_nxt = 1'b0;
      end else if (p0_r) begin
        p0_nxt   = !half_r;
        half_nxt = !half_r;
      end else begin
        p1_nxt   = !half_r;
        half_nxt = !half_r;
      end
      if (final_step) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      busy_nxt = 1'b1;
      err_nxt  = head_job.err;
      p0_nxt   = head_job.p0_v;
      p1_nxt   = head_job.p1_v;
      half_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (slot_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      err_r       <= 1'b0;
      p0_r        <= 1'b0;
      p1_r        <= 1'b0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      err_r       <= err_nxt;
      p0_r        <= p0_nxt;
      p1_r        <= p1_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a0_r <= head_job.p0_a;
      b0_r <= head_job.p0_b;
      a1_r <= head_job.p1_a;
    end
    if (step) begin
      out_letter_r <= res_letter;
      out_last_r   <= final_step;
      out_bad_r    <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_letter_out = out_letter_r;
  assign out_run_last   = out_last_r;
  assign out_bad_letter = out_bad_r;

  `PDC_ASSERT_IMPL(a_busy_has_work, clk, rst_n, busy_r, err_r || p0_r || p1_r, "idle job busy")
  `PDC_ASSERT_IMPL(a_rise_from_busy, clk, rst_n, $rose(out_valid_r), $past(busy_r), "result from no job")

endmodule

// ===== src/playfair_digraph_cipher_unit.sv =====
// Playfair cipher unit top level: configuration registers, front end, job queue
// and back end. Uses pdc_pkg, pdc_front, pdc_queue and pdc_back.
// Jobs are registered in the queue, then in the back end; each result in the output register.
// Throughput: one input transfer per cycle while the queue has room; the back end sends
// one result per cycle while out_stall is low, and an item yields up to 4 results.
// Reset: synchronous on rst_n; key square and mode return to their defaults, nothing held.
module playfair_digraph_cipher_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [pdc_pkg::LW-1:0]    in_letter_in,
  input  logic                      in_msg_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [pdc_pkg::LW-1:0]    out_letter_out,
  output logic                      out_run_last,
  output logic                      out_bad_letter,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pdc_pkg::IDX_W-1:0] cfg_index,
  input  logic [pdc_pkg::ROW_W-1:0] cfg_data
);
  import pdc_pkg::*;

  key_sq_t  key_r;
  logic     decrypt_r;
  logic     push, q_full, pop, head_valid;
  pdc_job_t push_job, head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= KEY_RESET;
      decrypt_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index <= REG_KEY_ROW_4) begin
        key_r[cfg_index] <= cfg_data;
      end else if (cfg_index == REG_DECRYPT_MODE) begin
        decrypt_r <= cfg_data[0];
      end
    end
  end

  pdc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .key          (key_r),
    .decrypt_mode (decrypt_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_letter_in (in_letter_in),
    .in_msg_end   (in_msg_end),
    .q_full       (q_full),
    .push         (push),
    .job          (push_job)
  );

  pdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  pdc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .key            (key_r),
    .decrypt_mode   (decrypt_r),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_letter_out (out_letter_out),
    .out_run_last   (out_run_last),
    .out_bad_letter (out_bad_letter)
  );

endmodule
